// ----- design/cffa_pkg.sv -----
// ----------------------------------------------------------------------------
// cffa_pkg
// Shared codes, register defaults and pipeline item types for the cube face
// to frame address block.
// ----------------------------------------------------------------------------
package cffa_pkg;

   localparam logic [2:0] FACE_LEFT  = 3'd0;
   localparam logic [2:0] FACE_RIGHT = 3'd1;
   localparam logic [2:0] FACE_FRONT = 3'd2;
   localparam logic [2:0] FACE_BACK  = 3'd3;
   localparam logic [2:0] FACE_TOP   = 3'd4;
   localparam logic [2:0] FACE_DOWN  = 3'd5;

   localparam logic [2:0] CSR_FRAME_WIDTH  = 3'd0;
   localparam logic [2:0] CSR_FRAME_HEIGHT = 3'd1;
   localparam logic [2:0] CSR_SIDE_WIDTH   = 3'd2;
   localparam logic [2:0] CSR_CENTER_WIDTH = 3'd3;
   localparam logic [2:0] CSR_BLEND_WIDTH  = 3'd4;

   localparam logic [13:0] RST_FRAME_WIDTH  = 14'd4096;
   localparam logic [12:0] RST_FRAME_HEIGHT = 13'd1344;
   localparam logic [12:0] RST_SIDE_WIDTH   = 13'd1376;
   localparam logic [12:0] RST_CENTER_WIDTH = 13'd1344;
   localparam logic [7:0]  RST_BLEND_WIDTH  = 8'd32;

   typedef struct packed {
      logic legal;
      logic sel;
      logic side;
      logic far;
   } meta_type;

   typedef struct packed {
      logic        sel;
      logic [23:0] first;
      logic [23:0] second;
      logic        blended;
      logic        wt_en;
   } result_type;

endpackage

// ----- design/cube_face_to_frame_address.sv -----
// ----------------------------------------------------------------------------
// cube_face_to_frame_address
// Maps a face point to primary and secondary pixel addresses with a band
// blend weight, fully pipelined.
// ----------------------------------------------------------------------------
// Pipeline: capture, products, columns, addresses, then the weight divider,
// which resolves one quotient bit per stage.
// Throughput: one item per clock, busy is high only in reset and the cycle after.
// Reset: synchronous, clears all valid bits and loads register defaults.
// The receiver cannot stall; each result is shown for one cycle.
// ----------------------------------------------------------------------------
module cube_face_to_frame_address
   import cffa_pkg::*;
#(
   parameter int FRAC_BITS   = 16,
   parameter int WEIGHT_BITS = 8,
   parameter int INDEX_BITS  = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_face,
   input  logic [15:0] req_u_coord,
   input  logic [15:0] req_v_coord,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [13:0] csr_wdata,
   output logic        rsp_valid,
   output logic        rsp_frame_select,
   output logic [23:0] rsp_first_index,
   output logic [23:0] rsp_second_index,
   output logic [7:0]  rsp_blend_weight,
   output logic        rsp_blended
);

   localparam int F      = FRAC_BITS;
   localparam int UkW    = F + 15;
   localparam int SumW   = F + 18;
   localparam int NumW   = F + 10;
   localparam int DivW   = F + 11 + WEIGHT_BITS;
   localparam int Lat    = WEIGHT_BITS + 4;
   localparam logic [27:0] IndexMask = 28'((29'(1) << INDEX_BITS) - 29'(1));

   // configuration
   logic [13:0] frame_width_ff;
   logic [12:0] frame_height_ff, side_width_ff, center_width_ff;
   logic [7:0]  blend_width_ff;
   logic        busy_ff;

   assign csr_ready = 1'b1;
   assign busy      = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= RST_FRAME_WIDTH;
         frame_height_ff <= RST_FRAME_HEIGHT;
         side_width_ff   <= RST_SIDE_WIDTH;
         center_width_ff <= RST_CENTER_WIDTH;
         blend_width_ff  <= RST_BLEND_WIDTH;
         busy_ff         <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
         if (csr_valid) begin
            case (csr_index)
               CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata;
               CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata[12:0];
               CSR_SIDE_WIDTH:   side_width_ff   <= csr_wdata[12:0];
               CSR_CENTER_WIDTH: center_width_ff <= csr_wdata[12:0];
               CSR_BLEND_WIDTH:  blend_width_ff  <= csr_wdata[7:0];
               default: ;
            endcase
         end
      end
   end

   // derived constants; kept static while items are in flight by the user only
   logic signed [13:0] k_ff, w4b_ff;
   logic [13:0]        w2b_ff, wc_ff;
   logic [NumW-1:0]    den_ff, b2_ff;
   logic [DivW-1:0]    y_ff;
   logic               b_nz_ff;

   always_ff @(posedge clock) begin
      k_ff    <= $signed({1'b0, side_width_ff}) - $signed({5'b0, blend_width_ff, 1'b0});
      w4b_ff  <= $signed({1'b0, side_width_ff}) - $signed({4'b0, blend_width_ff, 2'b0});
      w2b_ff  <= {1'b0, side_width_ff} + {5'b0, blend_width_ff, 1'b0};
      wc_ff   <= {1'b0, side_width_ff} + {1'b0, center_width_ff};
      den_ff  <= NumW'({blend_width_ff, 2'b0}) << F;
      b2_ff   <= NumW'({blend_width_ff, 1'b0}) << F;
      y_ff    <= DivW'({blend_width_ff, 3'b0}) << F;
      b_nz_ff <= (blend_width_ff != 8'd0);
   end

   // stage 1: capture, rotate
   logic         s1_valid_ff;
   logic [F-1:0] s1_u_ff, s1_v_ff;
   meta_type     s1_meta_ff;
   logic [F-1:0] u_in, v_in;
   meta_type     meta_in;

   always_comb begin
      u_in = F'(req_u_coord);
      v_in = F'(req_v_coord);
      if (req_face >= FACE_BACK) begin
         u_in = F'(req_v_coord);
         v_in = ~F'(req_u_coord);
      end
      meta_in.legal = (req_face <= FACE_DOWN);
      meta_in.sel   = (req_face >= FACE_BACK);
      meta_in.side  = (req_face != FACE_FRONT) && (req_face != FACE_BACK);
      meta_in.far   = (req_face == FACE_RIGHT) || (req_face == FACE_TOP);
   end

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else       s1_valid_ff <= start && !busy_ff;
      s1_u_ff    <= u_in;
      s1_v_ff    <= v_in;
      s1_meta_ff <= meta_in;
   end

   // stage 2: products
   logic                  s2_valid_ff;
   logic [F+12:0]         s2_vh_ff, s2_uc_ff;
   logic signed [UkW-1:0] s2_uk_ff;
   meta_type              s2_meta_ff;
   logic signed [UkW-1:0] uk_in;

   assign uk_in = $signed({1'b0, s1_u_ff}) * k_ff;

   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else       s2_valid_ff <= s1_valid_ff;
      s2_vh_ff   <= (F + 13)'(s1_v_ff) * (F + 13)'(frame_height_ff);
      s2_uc_ff   <= (F + 13)'(s1_u_ff) * (F + 13)'(center_width_ff);
      s2_uk_ff   <= uk_in;
      s2_meta_ff <= s1_meta_ff;
   end

   // stage 3: columns, band tests, weight numerator, row times width
   logic                   s3_valid_ff;
   logic [26:0]            s3_rowfw_ff;
   logic [15:0]            s3_col1_ff, s3_col2_ff;
   logic                   s3_blend_ff;
   logic [NumW-1:0]        s3_num_ff;
   meta_type               s3_meta_ff;
   logic signed [SumW-1:0] two_uk, k_sh, w4b_sh, w2b_sh, b2_sh, den_sh, rt, num;
   logic [14:0]            col_r;
   logic [12:0]            col_l;
   logic [13:0]            base;
   logic                   left_hit, right_hit;
   logic [15:0]            col1_in, col2_in;
   logic                   blend_in;
   logic [NumW-1:0]        num_in;

   always_comb begin
      two_uk    = SumW'(s2_uk_ff) <<< 1;
      k_sh      = SumW'(k_ff) <<< F;
      w4b_sh    = SumW'(w4b_ff) <<< F;
      w2b_sh    = SumW'($signed({1'b0, w2b_ff})) <<< F;
      b2_sh     = SumW'($signed({1'b0, b2_ff}));
      den_sh    = SumW'($signed({1'b0, den_ff}));
      left_hit  = (two_uk <= w4b_sh);
      right_hit = ((two_uk - k_sh) >= b2_sh);
      rt        = two_uk - k_sh + w2b_sh;
      col_r     = (rt < 0) ? 15'd0 : rt[F+15:F+1];
      col_l     = (s2_uk_ff < 0) ? 13'd0 : s2_uk_ff[F+12:F];
      base      = s2_meta_ff.far ? wc_ff : 14'd0;
      num       = two_uk - w4b_sh;
      if (num < 0)           num_in = '0;
      else if (num > den_sh) num_in = den_ff;
      else                   num_in = num[NumW-1:0];
      blend_in = 1'b0;
      if (!s2_meta_ff.side) begin
         col1_in = 16'(side_width_ff) + 16'(s2_uc_ff[F+12:F]);
         col2_in = col1_in;
      end else if (left_hit) begin
         col1_in = 16'(base) + 16'(col_l);
         col2_in = col1_in;
      end else if (right_hit) begin
         col1_in = 16'(base) + 16'(col_r);
         col2_in = col1_in;
      end else begin
         col1_in  = 16'(base) + 16'(col_l);
         col2_in  = 16'(base) + 16'(col_r);
         blend_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s3_valid_ff <= 1'b0;
      else       s3_valid_ff <= s2_valid_ff;
      s3_rowfw_ff <= 27'(s2_vh_ff[F+12:F]) * 27'(frame_width_ff);
      s3_col1_ff  <= col1_in;
      s3_col2_ff  <= col2_in;
      s3_blend_ff <= blend_in;
      s3_num_ff   <= num_in;
      s3_meta_ff  <= s2_meta_ff;
   end

   // stage 4: addresses, divider dividend
   logic            s4_valid_ff;
   logic [DivW-1:0] s4_x_ff;
   result_type      s4_pay_ff;
   logic [27:0]     sum1, sum2;
   result_type      pay_in;

   always_comb begin
      sum1           = (28'(s3_rowfw_ff) + 28'(s3_col1_ff)) & IndexMask;
      sum2           = (28'(s3_rowfw_ff) + 28'(s3_col2_ff)) & IndexMask;
      pay_in.sel     = s3_meta_ff.sel;
      pay_in.first   = sum1[23:0];
      pay_in.second  = sum2[23:0];
      pay_in.blended = s3_blend_ff;
      pay_in.wt_en   = s3_blend_ff && b_nz_ff;
      if (!s3_meta_ff.legal) begin
         pay_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s4_valid_ff <= 1'b0;
      else       s4_valid_ff <= s3_valid_ff;
      s4_x_ff   <= (DivW'(s3_num_ff) << (WEIGHT_BITS + 1)) - (DivW'(s3_num_ff) << 1)
                   + DivW'(den_ff);
      s4_pay_ff <= pay_in;
   end

   // weight divider, one quotient bit per stage, msb first
   logic                   dv_valid_ff [WEIGHT_BITS];
   logic [DivW-1:0]        dv_rem_ff   [WEIGHT_BITS];
   logic [WEIGHT_BITS-1:0] dv_q_ff     [WEIGHT_BITS];
   result_type             dv_pay_ff   [WEIGHT_BITS];

   for (genvar j = 0; j < WEIGHT_BITS; j++) begin : g_div
      logic                   valid_prev;
      logic [DivW-1:0]        rem_prev, ysh, rem_in;
      logic [WEIGHT_BITS-1:0] q_prev, q_in;
      result_type             pay_prev;

      if (j == 0) begin : g_first
         assign valid_prev = s4_valid_ff;
         assign rem_prev   = s4_x_ff;
         assign q_prev     = '0;
         assign pay_prev   = s4_pay_ff;
      end else begin : g_next
         assign valid_prev = dv_valid_ff[j-1];
         assign rem_prev   = dv_rem_ff[j-1];
         assign q_prev     = dv_q_ff[j-1];
         assign pay_prev   = dv_pay_ff[j-1];
      end

      always_comb begin
         ysh    = y_ff << (WEIGHT_BITS - 1 - j);
         rem_in = rem_prev;
         q_in   = q_prev;
         if (rem_prev >= ysh) begin
            rem_in = rem_prev - ysh;
            q_in   = q_prev | (WEIGHT_BITS'(1) << (WEIGHT_BITS - 1 - j));
         end
      end

      always_ff @(posedge clock) begin
         if (reset) dv_valid_ff[j] <= 1'b0;
         else       dv_valid_ff[j] <= valid_prev;
         dv_rem_ff[j] <= rem_in;
         dv_q_ff[j]   <= q_in;
         dv_pay_ff[j] <= pay_prev;
      end
   end

   result_type last_pay;

   assign last_pay         = dv_pay_ff[WEIGHT_BITS-1];
   assign rsp_valid        = dv_valid_ff[WEIGHT_BITS-1];
   assign rsp_frame_select = last_pay.sel;
   assign rsp_first_index  = last_pay.first;
   assign rsp_second_index = last_pay.second;
   assign rsp_blended      = last_pay.blended;
   assign rsp_blend_weight = last_pay.wt_en ? 8'(dv_q_ff[WEIGHT_BITS-1]) : 8'd0;

   // checks
   a_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##Lat rsp_valid)
      else $error("accepted item did not emerge on time");

   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, Lat))
      else $error("result without an accepted item");

   a_single_pixel : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_blended) |->
         (rsp_second_index == rsp_first_index) && (rsp_blend_weight == 8'd0))
      else $error("unblended item carries a second pixel or weight");

endmodule

// ----- test/cube_face_to_frame_address_tb.sv -----
// ----------------------------------------------------------------------------
// cube_face_to_frame_address_tb
// Drives face points into the frame address block in bursts with random gaps,
// under default, extreme and random strip geometries. A scoreboard works out
// the expected addresses, band weight and frame select for every accepted
// item and checks each result strobe against the oldest one outstanding.
// ----------------------------------------------------------------------------
module cube_face_to_frame_address_tb;
   import cffa_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam longint FRAC_ONE   = 65536;
   localparam longint FRAC_MAX   = 65535;
   localparam longint WEIGHT_TOP = 255;
   localparam int     IDLE_LIMIT = 1000;
   localparam int     TAIL_WAIT  = 40;

   typedef struct packed {
      logic        frame_select;
      logic [23:0] first_index;
      logic [23:0] second_index;
      logic [7:0]  blend_weight;
      logic        blended;
   } frame_address_type;

   class address_scoreboard;
      logic [13:0] frame_width;
      logic [12:0] frame_height;
      logic [12:0] side_width;
      logic [12:0] center_width;
      logic [7:0]  blend_width;
      frame_address_type pending_addresses[$];
      int unsigned failures;

      function new();
         frame_width  = RST_FRAME_WIDTH;
         frame_height = RST_FRAME_HEIGHT;
         side_width   = RST_SIDE_WIDTH;
         center_width = RST_CENTER_WIDTH;
         blend_width  = RST_BLEND_WIDTH;
         failures     = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [13:0] data);
         case (idx)
            CSR_FRAME_WIDTH:  frame_width  = data;
            CSR_FRAME_HEIGHT: frame_height = data[12:0];
            CSR_SIDE_WIDTH:   side_width   = data[12:0];
            CSR_CENTER_WIDTH: center_width = data[12:0];
            CSR_BLEND_WIDTH:  blend_width  = data[7:0];
            default: ;
         endcase
      endfunction

      function longint floor_pos(longint num, int sh);
         if (num < 0)
            return 0;
         return num >>> sh;
      endfunction

      function logic [23:0] index_of(longint row, longint col);
         longint sum;
         sum = row * longint'(frame_width) + col;
         return sum[23:0];
      endfunction

      function frame_address_type map_point(logic [2:0] face, logic [15:0] u_in,
                                            logic [15:0] v_in);
         frame_address_type r;
         longint u, v, t, row, w, b, cw, k, twou, base, col_l, col_r, num, den, wt;
         r = '0;
         if (face > FACE_DOWN)
            return r;
         u = u_in;
         v = v_in;
         if (face >= FACE_BACK) begin
            t = u;
            u = v;
            v = FRAC_MAX - t;
         end
         r.frame_select = (face >= FACE_BACK);
         w   = side_width;
         b   = blend_width;
         cw  = center_width;
         row = (v * longint'(frame_height)) >>> 16;
         if (face == FACE_FRONT || face == FACE_BACK) begin
            r.first_index  = index_of(row, w + ((u * cw) >>> 16));
            r.second_index = r.first_index;
         end else begin
            k     = w - 2 * b;
            twou  = 2 * u - FRAC_ONE;
            base  = (face == FACE_RIGHT || face == FACE_TOP) ? w + cw : 0;
            col_l = base + floor_pos(u * k, 16);
            col_r = base + floor_pos(k * twou + (w + 2 * b) * FRAC_ONE, 17);
            if (2 * u * k <= (w - 4 * b) * FRAC_ONE) begin
               r.first_index  = index_of(row, col_l);
               r.second_index = r.first_index;
            end else if (k * twou >= 2 * b * FRAC_ONE) begin
               r.first_index  = index_of(row, col_r);
               r.second_index = r.first_index;
            end else begin
               r.first_index  = index_of(row, col_l);
               r.second_index = index_of(row, col_r);
               r.blended      = 1'b1;
               num = 2 * u * k - (w - 4 * b) * FRAC_ONE;
               den = 4 * b * FRAC_ONE;
               if (den > 0) begin
                  if (num < 0)
                     num = 0;
                  if (num > den)
                     num = den;
                  wt = (num * WEIGHT_TOP * 2 + den) / (2 * den);
                  if (wt > WEIGHT_TOP)
                     wt = WEIGHT_TOP;
                  r.blend_weight = wt[7:0];
               end
            end
         end
         return r;
      endfunction

      function void note_item(logic [2:0] face, logic [15:0] u_in, logic [15:0] v_in);
         pending_addresses.push_back(map_point(face, u_in, v_in));
      endfunction

      function void check_result(frame_address_type got);
         frame_address_type want;
         if (pending_addresses.size() == 0) begin
            $error("result with no item outstanding");
            failures++;
            return;
         end
         want = pending_addresses.pop_front();
         if (got.frame_select !== want.frame_select) begin
            $error("frame_select expected %0d got %0d", want.frame_select, got.frame_select);
            failures++;
         end
         if (got.first_index !== want.first_index) begin
            $error("first_index expected %0d got %0d", want.first_index, got.first_index);
            failures++;
         end
         if (got.second_index !== want.second_index) begin
            $error("second_index expected %0d got %0d", want.second_index, got.second_index);
            failures++;
         end
         if (got.blend_weight !== want.blend_weight) begin
            $error("blend_weight expected %0d got %0d", want.blend_weight, got.blend_weight);
            failures++;
         end
         if (got.blended !== want.blended) begin
            $error("blended expected %0d got %0d", want.blended, got.blended);
            failures++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_face = '0;
   logic [15:0] req_u_coord = '0;
   logic [15:0] req_v_coord = '0;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [13:0] csr_wdata = '0;
   logic        rsp_valid;
   logic        rsp_frame_select;
   logic [23:0] rsp_first_index;
   logic [23:0] rsp_second_index;
   logic [7:0]  rsp_blend_weight;
   logic        rsp_blended;

   address_scoreboard sb = new();
   int unsigned idle_cycles = 0;

   cube_face_to_frame_address DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_face         (req_face),
      .req_u_coord      (req_u_coord),
      .req_v_coord      (req_v_coord),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_frame_select (rsp_frame_select),
      .rsp_first_index  (rsp_first_index),
      .rsp_second_index (rsp_second_index),
      .rsp_blend_weight (rsp_blend_weight),
      .rsp_blended      (rsp_blended)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid)
            sb.check_result({rsp_frame_select, rsp_first_index, rsp_second_index,
                             rsp_blend_weight, rsp_blended});
         if (start && !busy)
            sb.note_item(req_face, req_u_coord, req_v_coord);
         if (csr_valid && csr_ready)
            sb.write_reg(csr_index, csr_wdata);
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   task automatic send_item(logic [2:0] face, logic [15:0] u_in, logic [15:0] v_in);
      start       <= 1'b1;
      req_face    <= face;
      req_u_coord <= u_in;
      req_v_coord <= v_in;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic pause_items(int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (sb.pending_addresses.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, int unsigned data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data[13:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic set_geometry(int unsigned fw, int unsigned fh, int unsigned sw,
                               int unsigned cw, int unsigned bw, bit stray);
      start <= 1'b0;
      wait_drained();
      csr_write(CSR_FRAME_WIDTH, fw);
      csr_write(CSR_FRAME_HEIGHT, fh);
      csr_write(CSR_SIDE_WIDTH, sw);
      csr_write(CSR_CENTER_WIDTH, cw);
      csr_write(CSR_BLEND_WIDTH, bw);
      // unmapped index, must leave the geometry alone
      if (stray)
         csr_write(3'(CSR_BLEND_WIDTH + $urandom_range(1, 3)), $urandom_range(0, 16383));
      csr_valid <= 1'b0;
   endtask

   // coordinate clustered around the overlap band of a side face
   function automatic logic [15:0] band_coord();
      longint k, sp, c;
      k  = longint'(sb.side_width) - 2 * longint'(sb.blend_width);
      sp = (k > 0) ? (longint'(sb.blend_width) * 32768) / k + 4 : 32768;
      if (sp > 32768)
         sp = 32768;
      c = 32768 - sp + longint'($urandom_range(0, 2 * sp));
      if (c < 0)
         c = 0;
      if (c > FRAC_MAX)
         c = FRAC_MAX;
      return c[15:0];
   endfunction

   task automatic random_items(int count);
      int sent, burst, pick;
      logic [2:0]  face;
      logic [15:0] u_in, v_in;
      sent = 0;
      while (sent < count) begin
         burst = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 30);
         if (burst > count - sent)
            burst = count - sent;
         repeat (burst) begin
            pick = $urandom_range(0, 15);
            face = (pick < 14) ? 3'(pick % 6) : 3'(pick - 8);
            u_in = $urandom_range(0, 65535);
            v_in = $urandom_range(0, 65535);
            if ($urandom_range(0, 2) == 0) begin
               if (face == FACE_LEFT || face == FACE_RIGHT)
                  u_in = band_coord();
               else if (face == FACE_TOP || face == FACE_DOWN)
                  v_in = band_coord();
            end
            if ($urandom_range(0, 15) == 0)
               u_in = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            if ($urandom_range(0, 15) == 0)
               v_in = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            send_item(face, u_in, v_in);
            sent++;
         end
         pause_items(($urandom_range(0, 5) == 0) ? $urandom_range(8, 25)
                                                 : $urandom_range(0, 4));
      end
   endtask

   task automatic random_geometry();
      int unsigned sw, bmax;
      sw   = $urandom_range(8, 4096);
      bmax = (sw - 1) / 4;
      if (bmax > 255)
         bmax = 255;
      set_geometry($urandom_range(1, 8192), $urandom_range(1, 4096), sw,
                   $urandom_range(1, 4096), $urandom_range(1, bmax), 1'b1);
   endtask

   initial begin
      logic [2:0] f;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // default geometry: every face at both corners, then the band edges
      for (int i = 0; i < 8; i++) begin
         f = 3'(i);
         send_item(f, 16'h0000, 16'h0000);
         send_item(f, 16'hFFFF, 16'hFFFF);
      end
      send_item(FACE_LEFT, 16'd32768, 16'd100);
      send_item(FACE_RIGHT, 16'd32768, 16'hFFFF);
      send_item(FACE_TOP, 16'd0, 16'd32768);
      send_item(FACE_DOWN, 16'hFFFF, 16'd32768);
      send_item(FACE_LEFT, 16'd31169, 16'd500);
      send_item(FACE_LEFT, 16'd31170, 16'd500);
      send_item(FACE_RIGHT, 16'd34366, 16'd500);
      send_item(FACE_RIGHT, 16'd34367, 16'd500);
      send_item(FACE_FRONT, 16'hFFFF, 16'h0000);
      pause_items(3);
      random_items(130);

      set_geometry(1, 1, 1, 1, 1, 1'b0);
      random_items(120);
      set_geometry(0, 0, 0, 0, 0, 1'b1);
      random_items(100);
      set_geometry(8192, 4096, 4096, 4096, 255, 1'b0);
      random_items(130);
      set_geometry(16383, 16383, 16383, 16383, 16383, 1'b1);
      random_items(120);
      // no overlap band
      set_geometry(4096, 1344, 1376, 1344, 0, 1'b0);
      random_items(120);
      // side strip narrower than the band
      set_geometry(2000, 800, 1, 300, 255, 1'b0);
      random_items(120);
      set_geometry(3840, 1920, 1600, 640, 40, 1'b0);
      random_items(130);
      repeat (3) begin
         random_geometry();
         random_items(130);
      end
      set_geometry(RST_FRAME_WIDTH, RST_FRAME_HEIGHT, RST_SIDE_WIDTH,
                   RST_CENTER_WIDTH, RST_BLEND_WIDTH, 1'b0);
      random_items(90);

      start <= 1'b0;
      wait_drained();
      repeat (TAIL_WAIT) @(posedge clock);
      if (sb.failures == 0 && sb.pending_addresses.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
